// ===== rtl/core/sbda_pkg.sv =====
`default_nettype none

package sbda_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Queue fill status seen by both sides of the queue.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Add three to a BCD digit of five or more, ahead of the shift.
    function automatic logic [3:0] dabble_adjust(input logic [3:0] digit);
        logic [3:0] result;
        begin
            if (digit >= 4'd5)
            begin
                result = digit + 4'd3;
            end
            else
            begin
                result = digit;
            end
            return result;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sbda_front.sv =====
`default_nettype none

module sbda_front #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                  start,
    input  wire logic signed [WORD_BITS-1:0] word,
    input  wire sbda_pkg::queue_status_t status,
    output logic                       busy,
    output logic                       push,
    output logic                       push_neg,
    output logic [WORD_BITS-1:0]       push_mag
);

    logic [WORD_BITS-1:0] word_bits;

    assign word_bits = word;
    assign busy      = status.full;
    assign push      = start && !status.full;
    assign push_neg  = word_bits[WORD_BITS-1];

    // Two's complement magnitude; the most negative word maps to 2^(N-1) unsigned.
    assign push_mag = push_neg ? ((~word_bits) + {{(WORD_BITS-1){1'b0}}, 1'b1})
                               : word_bits;

endmodule

`default_nettype wire

// ===== rtl/core/sbda_queue.sv =====
`default_nettype none

module sbda_queue #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic                 push_neg,
    input  wire logic [WORD_BITS-1:0] push_mag,
    input  wire logic                 pop,
    output logic                      head_neg,
    output logic [WORD_BITS-1:0]      head_mag,
    output sbda_pkg::queue_status_t   status
);

    logic                 neg_reg [2];
    logic [WORD_BITS-1:0] mag_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg;
    logic                 wr_ptr_next;
    logic                 rd_ptr_next;
    logic [1:0]           count_next;
    logic                 do_push;
    logic                 do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_neg     = neg_reg[rd_ptr_reg];
    assign head_mag     = mag_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            neg_reg[wr_ptr_reg] <= push_neg;
            mag_reg[wr_ptr_reg] <= push_mag;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sbda_back.sv =====
`default_nettype none

module sbda_back #(
    parameter int WORD_BITS      = 32,
    parameter int DECIMAL_DIGITS = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sbda_pkg::queue_status_t status,
    input  wire logic                 head_neg,
    input  wire logic [WORD_BITS-1:0] head_mag,
    output logic                      pop,
    output logic                      strobe,
    output logic [7:0]                character,
    output logic                      last
);

    localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int IDX_W = (DECIMAL_DIGITS > 1) ? $clog2(DECIMAL_DIGITS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [WORD_BITS-1:0] mag_reg;
    logic [WORD_BITS-1:0] mag_next;
    logic [3:0]           digits_reg [DECIMAL_DIGITS];
    logic [3:0]           digits_next [DECIMAL_DIGITS];
    logic [3:0]           adj_digit [DECIMAL_DIGITS];
    logic [CNT_W-1:0]     bit_cnt_reg;
    logic [CNT_W-1:0]     bit_cnt_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic                 sign_pending_reg;
    logic                 sign_pending_next;
    logic                 strobe_reg;
    logic                 strobe_next;
    logic [7:0]           char_reg;
    logic [7:0]           char_next;
    logic                 last_reg;
    logic                 last_next;
    logic [3:0]           cur_digit;

    assign cur_digit = digits_reg[idx_reg];
    assign pop       = (state_reg == ST_IDLE) && !status.empty;
    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next        = state_reg;
        mag_next          = mag_reg;
        bit_cnt_next      = bit_cnt_reg;
        idx_next          = idx_reg;
        neg_next          = neg_reg;
        sign_pending_next = sign_pending_reg;
        strobe_next       = 1'b0;
        char_next         = char_reg;
        last_next         = last_reg;

        // One double-dabble step: adjust every digit, then shift the chain left.
        for (int d = 0; d < DECIMAL_DIGITS; d++)
        begin
            adj_digit[d] = sbda_pkg::dabble_adjust(digits_reg[d]);
        end
        for (int d = 0; d < DECIMAL_DIGITS; d++)
        begin
            digits_next[d] = digits_reg[d];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!status.empty)
                begin
                    mag_next     = head_mag;
                    neg_next     = head_neg;
                    bit_cnt_next = CNT_W'(WORD_BITS - 1);
                    for (int d = 0; d < DECIMAL_DIGITS; d++)
                    begin
                        digits_next[d] = 4'd0;
                    end
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                digits_next[0] = {adj_digit[0][2:0], mag_reg[WORD_BITS-1]};
                for (int d = 1; d < DECIMAL_DIGITS; d++)
                begin
                    digits_next[d] = {adj_digit[d][2:0], adj_digit[d-1][3]};
                end
                mag_next     = {mag_reg[WORD_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - {{(CNT_W-1){1'b0}}, 1'b1};
                if (bit_cnt_reg == '0)
                begin
                    idx_next   = IDX_W'(DECIMAL_DIGITS - 1);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros; the units digit always prints.
                if ((cur_digit == 4'd0) && (idx_reg != '0))
                begin
                    idx_next = idx_reg - {{(IDX_W-1){1'b0}}, 1'b1};
                end
                else
                begin
                    sign_pending_next = neg_reg && (cur_digit != 4'd0);
                    state_next        = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                if (sign_pending_reg)
                begin
                    char_next         = sbda_pkg::CHAR_MINUS;
                    last_next         = 1'b0;
                    sign_pending_next = 1'b0;
                end
                else
                begin
                    char_next = sbda_pkg::CHAR_ZERO + {4'd0, cur_digit};
                    last_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - {{(IDX_W-1){1'b0}}, 1'b1};
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mag_reg          <= '0;
            bit_cnt_reg      <= '0;
            idx_reg          <= '0;
            neg_reg          <= 1'b0;
            sign_pending_reg <= 1'b0;
            strobe_reg       <= 1'b0;
            char_reg         <= 8'd0;
            last_reg         <= 1'b0;
            for (int d = 0; d < DECIMAL_DIGITS; d++)
            begin
                digits_reg[d] <= 4'd0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            mag_reg          <= mag_next;
            bit_cnt_reg      <= bit_cnt_next;
            idx_reg          <= idx_next;
            neg_reg          <= neg_next;
            sign_pending_reg <= sign_pending_next;
            strobe_reg       <= strobe_next;
            char_reg         <= char_next;
            last_reg         <= last_next;
            for (int d = 0; d < DECIMAL_DIGITS; d++)
            begin
                digits_reg[d] <= digits_next[d];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/signed_binary_to_decimal_ascii.sv =====
// Each request waits in the queue, then passes through the dabble loop, one bit per
// cycle, and the digit walk, which skips leading zeros and emits the digits, after a
// minus sign for a negative value.
// A two-entry queue takes requests while the converter works; busy means it is full.
// Characters come out one per cycle on strobe and cannot be stalled.
// rst_n asynchronously clears the queue and the converter; no request survives.
`default_nettype none

module signed_binary_to_decimal_ascii #(
    parameter int WORD_BITS      = 32,
    parameter int DECIMAL_DIGITS = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [WORD_BITS-1:0] word,
    output logic                             strobe,
    output logic [7:0]                       character,
    output logic                             last
);

    sbda_pkg::queue_status_t queue_status;
    logic                    push;
    logic                    push_neg;
    logic [WORD_BITS-1:0]    push_mag;
    logic                    pop;
    logic                    head_neg;
    logic [WORD_BITS-1:0]    head_mag;

    sbda_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .start    (start),
        .word     (word),
        .status   (queue_status),
        .busy     (busy),
        .push     (push),
        .push_neg (push_neg),
        .push_mag (push_mag)
    );

    sbda_queue #(
        .WORD_BITS (WORD_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_neg (push_neg),
        .push_mag (push_mag),
        .pop      (pop),
        .head_neg (head_neg),
        .head_mag (head_mag),
        .status   (queue_status)
    );

    sbda_back #(
        .WORD_BITS      (WORD_BITS),
        .DECIMAL_DIGITS (DECIMAL_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (queue_status),
        .head_neg  (head_neg),
        .head_mag  (head_mag),
        .pop       (pop),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/sbda_checker.sv =====
`default_nettype none

module sbda_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       strobe,
    input wire logic [7:0] character,
    input wire logic       last
);

    // Only a minus sign or a decimal digit ever goes out.
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ((character == 8'h2D) ||
                    ((character >= 8'h30) && (character <= 8'h39))))
        else $error("character out of range");

    // A minus sign is always followed by digits.
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (character == 8'h2D)) |-> !last)
        else $error("minus sign flagged last");

    // The text of one request goes out without gaps.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("gap inside text");

    // The next request needs a full conversion before its first character.
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("character right after last");

    // A leading zero never starts a multi-character text.
    a_no_leading_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && ($past(!strobe) || $past(last)) && (character == 8'h30)) |-> last)
        else $error("leading zero emitted");

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .strobe    (strobe),
    .character (character),
    .last      (last)
);

`default_nettype wire

// ===== dv/signed_binary_to_decimal_ascii_checker.sv =====
module signed_binary_to_decimal_ascii_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic signed [31:0] word,
    input  wire logic               strobe,
    input  wire logic [7:0]         character,
    input  wire logic               last,
    output int                      fails,
    output int                      pending
);

    logic [7:0] text_chars[$];
    logic       text_lasts[$];

    initial
    begin
        fails   = 0;
        pending = 0;
    end

    // Queue the decimal text of one request: sign, then digits high to low.
    function automatic void queue_decimal_text(input logic signed [31:0] value);
        longint    magnitude;
        int        digits[10];
        int        count;
        begin
            magnitude = (value < 0) ? -longint'(value) : longint'(value);
            count     = 0;
            while (magnitude != 0)
            begin
                digits[count] = int'(magnitude % 10);
                magnitude     = magnitude / 10;
                count++;
            end
            if (count == 0)
            begin
                text_chars.push_back(sbda_pkg::CHAR_ZERO);
                text_lasts.push_back(1'b1);
            end
            else
            begin
                if (value < 0)
                begin
                    text_chars.push_back(sbda_pkg::CHAR_MINUS);
                    text_lasts.push_back(1'b0);
                end
                for (int i = count - 1; i >= 0; i--)
                begin
                    text_chars.push_back(sbda_pkg::CHAR_ZERO + 8'(digits[i]));
                    text_lasts.push_back(i == 0);
                end
            end
        end
    endfunction

    always @(posedge clk)
    begin
        logic [7:0] want_char;
        logic       want_last;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (text_chars.size() == 0)
                begin
                    $display("%0t: unexpected character expected none actual %0d last %0d",
                             $time, character, last);
                    fails++;
                end
                else
                begin
                    want_char = text_chars.pop_front();
                    want_last = text_lasts.pop_front();
                    if (character !== want_char)
                    begin
                        $display("%0t: character expected %0d actual %0d",
                                 $time, want_char, character);
                        fails++;
                    end
                    if (last !== want_last)
                    begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, want_last, last);
                        fails++;
                    end
                end
            end
            if (start && !busy)
            begin
                queue_decimal_text(word);
            end
        end
        pending <= text_chars.size();
    end

endmodule

// ===== dv/tb_signed_binary_to_decimal_ascii.sv =====
module tb_signed_binary_to_decimal_ascii;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic signed [31:0] word  = '0;
    logic               busy;
    logic               strobe;
    logic [7:0]         character;
    logic               last;
    int                 fails;
    int                 pending;

    signed_binary_to_decimal_ascii dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .word      (word),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

    signed_binary_to_decimal_ascii_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .word      (word),
        .strobe    (strobe),
        .character (character),
        .last      (last),
        .fails     (fails),
        .pending   (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("tb_signed_binary_to_decimal_ascii failed");
        $finish;
    end

    // Called at a rising edge; returns at the edge that takes the request.
    task automatic send_word(input logic signed [31:0] value, input bit may_idle);
        bit  taken;
        begin
            taken = 1'b0;
            while (!taken)
            begin
                if (may_idle && $urandom_range(0, 99) < 26)
                begin
                    // idle this cycle
                    start <= 1'b0;
                    word  <= $urandom;
                    @(posedge clk);
                end
                else
                begin
                    start <= 1'b1;
                    word  <= value;
                    // busy is settled by the falling edge; it holds through the next rise
                    @(negedge clk);
                    taken = !busy;
                    @(posedge clk);
                end
            end
        end
    endtask

    task automatic drain_text();
        begin
            start <= 1'b0;
            @(negedge clk);
            while (pending != 0)
            begin
                @(negedge clk);
            end
            @(posedge clk);
        end
    endtask

    logic signed [31:0] directed_words[24] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
        32'sd100, -32'sd101, 32'sd2147483647, 32'sh8000_0000, -32'sd2147483647,
        32'sd1000000000, -32'sd1000000000, 32'sd999999999, 32'sd1234567890,
        -32'sd1234567890, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd5, 32'sd4,
        32'sd1000000001, -32'sd7
    };

    initial
    begin
        logic signed [31:0] value;
        longint             span;
        int                 digit_count;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_words[i])
        begin
            send_word(directed_words[i], i > 4);
        end
        drain_text();

        for (int n = 0; n < 126; n++)
        begin
            case ($urandom_range(0, 3))
                0: value = $urandom;
                1:
                begin
                    // spread the number of digits evenly
                    digit_count = $urandom_range(1, 9);
                    span = 1;
                    repeat (digit_count) span *= 10;
                    value = $urandom_range(0, 32'(span - 1));
                    if ($urandom_range(0, 1))
                    begin
                        value = -value;
                    end
                end
                2:
                begin
                    // around powers of ten, where the digit count changes
                    digit_count = $urandom_range(0, 9);
                    span = 1;
                    repeat (digit_count) span *= 10;
                    value = 32'(span) + $urandom_range(0, 2) - 1;
                    if ($urandom_range(0, 1))
                    begin
                        value = -value;
                    end
                end
                default:
                begin
                    if ($urandom_range(0, 1))
                    begin
                        value = 32'sh8000_0000 + $urandom_range(0, 15);
                    end
                    else
                    begin
                        value = 32'sh7FFF_FFFF - $urandom_range(0, 15);
                    end
                end
            endcase
            send_word(value, n < 60 || n >= 110);
            if (n == 40)
            begin
                drain_text();
            end
        end

        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (60) @(posedge clk);
        if (fails == 0)
        begin
            $display("tb_signed_binary_to_decimal_ascii passed");
        end
        else
        begin
            $display("tb_signed_binary_to_decimal_ascii failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sbda_pkg.sv
rtl/core/sbda_front.sv
rtl/core/sbda_queue.sv
rtl/core/sbda_back.sv
rtl/core/signed_binary_to_decimal_ascii.sv
rtl/core/sbda_checker.sv
dv/signed_binary_to_decimal_ascii_checker.sv
dv/tb_signed_binary_to_decimal_ascii.sv
